// ===== rtl/ezp_pkg.sv =====
// ezp_pkg: shared types, constants and codes for the emergency zone proximity check
// used by ezp_arith, the top level and its checker; no dependencies
`default_nettype none

package ezp_pkg;

    // serial arithmetic unit sizes
    localparam int ACC_W      = 54;
    localparam int OPB_W      = 24;
    localparam int CNT_W      = 6;
    localparam int DIV_STEPS  = 32;
    localparam int SQRT_STEPS = 27;

    // ports
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 40;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 14;

    // parameter defaults
    localparam int SCALE_FLOOR_PCT_DEF = 50;
    localparam int SCALE_SPEED_DEF     = 1000;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRONT      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REAR       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MARGIN_F   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MARGIN_R   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MARGIN_S   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DECEL      = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_REACTION   = 3'd7;

    localparam logic CMD_START = 1'b0;

    typedef enum logic [1:0] {
        OP_MUL,
        OP_DIV,
        OP_SQRT
    } arith_op_t;

    typedef struct packed {
        logic             start;
        arith_op_t        op;
        logic [ACC_W-1:0] a;
        logic [OPB_W-1:0] b;
        logic [CNT_W-1:0] n;
    } arith_req_t;

    typedef struct packed {
        logic             done;
        logic [ACC_W-1:0] res;
    } arith_rsp_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_BRK_SQ,
        ST_BRK_DIV,
        ST_RT_MUL,
        ST_RT_DIV,
        ST_MRG_MUL,
        ST_MRG_DIV,
        ST_START_FIN,
        ST_PT_PREP,
        ST_QX,
        ST_QY,
        ST_QX_SQ,
        ST_QY_SQ,
        ST_N_SQRT,
        ST_BX_SQ,
        ST_BY_SQ,
        ST_D_SQRT,
        ST_HA,
        ST_HB,
        ST_HC,
        ST_HA_SQ,
        ST_HB_SQ,
        ST_HC_SQ,
        ST_OUT
    } ezp_state_t;

endpackage

`default_nettype wire

// ===== rtl/ezp_arith.sv =====
// ezp_arith: bit-serial multiply, restoring divide and integer square root
// one bit (two radicand bits for the root) per cycle; depends on ezp_pkg
`default_nettype none

module ezp_arith
    import ezp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire arith_req_t req,
    output arith_rsp_t      rsp
);

    logic             busy_reg;
    logic             done_reg;
    arith_op_t        op_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [ACC_W-1:0] sa_reg;
    logic [OPB_W-1:0] sb_reg;
    logic [ACC_W-1:0] acc_reg;
    logic [29:0]      rem_reg;

    logic [ACC_W-1:0] sa_next;
    logic [OPB_W-1:0] sb_next;
    logic [ACC_W-1:0] acc_next;
    logic [29:0]      rem_next;

    logic [OPB_W:0]   div_rem;
    logic [31:0]      sq_rem;
    logic [31:0]      sq_trial;

    assign div_rem  = {rem_reg[OPB_W-1:0], sa_reg[31]};
    assign sq_rem   = {rem_reg, sa_reg[ACC_W-1:ACC_W-2]};
    assign sq_trial = {3'b000, acc_reg[26:0], 2'b01};

    always_comb
    begin
        sa_next  = sa_reg;
        sb_next  = sb_reg;
        acc_next = acc_reg;
        rem_next = rem_reg;
        case (op_reg)
            OP_MUL:
            begin
                if (sb_reg[0])
                begin
                    acc_next = acc_reg + sa_reg;
                end
                sa_next = {sa_reg[ACC_W-2:0], 1'b0};
                sb_next = {1'b0, sb_reg[OPB_W-1:1]};
            end
            OP_DIV:
            begin
                // restoring step, quotient bits enter at the bottom
                if (div_rem >= {1'b0, sb_reg})
                begin
                    rem_next = 30'(div_rem - {1'b0, sb_reg});
                    acc_next = {acc_reg[ACC_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = 30'(div_rem);
                    acc_next = {acc_reg[ACC_W-2:0], 1'b0};
                end
                sa_next = {sa_reg[ACC_W-2:0], 1'b0};
            end
            OP_SQRT:
            begin
                if (sq_rem >= sq_trial)
                begin
                    rem_next = 30'(sq_rem - sq_trial);
                    acc_next = {acc_reg[ACC_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = 30'(sq_rem);
                    acc_next = {acc_reg[ACC_W-2:0], 1'b0};
                end
                sa_next = {sa_reg[ACC_W-3:0], 2'b00};
            end
            default:
            begin
                sa_next = sa_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            op_reg  <= req.op;
            cnt_reg <= req.n;
            sa_reg  <= req.a;
            sb_reg  <= req.b;
            acc_reg <= '0;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            sa_reg  <= sa_next;
            sb_reg  <= sb_next;
            acc_reg <= acc_next;
            rem_reg <= rem_next;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.res  = acc_reg;

endmodule

`default_nettype wire

// ===== rtl/emergency_zone_proximity_check.sv =====
// emergency_zone_proximity_check: top level, sequencer and zone datapath
// depends on ezp_pkg and ezp_arith
`default_nettype none

// One item at a time goes through a single bit-serial arithmetic unit (multiply,
// divide, square root). A start item computes the brake distance and three scaled
// margins. A point item runs the exact ellipse test only when it lies close enough
// to the zone. Input is taken only while the sequencer is idle; a result sits in
// an output register and the next item is accepted while it waits. No clearing
// pass after reset.

module emergency_zone_proximity_check
    import ezp_pkg::*;
#(
    parameter int SCALE_FLOOR_PCT = SCALE_FLOOR_PCT_DEF,
    parameter int SCALE_SPEED     = SCALE_SPEED_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // speed [12:0], point_x [28:13], point_y [44:29], zero [47:45]
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    // command
    input  wire logic                  s_tuser,
    input  wire logic                  s_tlast,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // min_normalized [15:0], footprint_dist [31:16], emergency [32], zero [39:33]
    output logic [OUT_DATA_W-1:0]      m_tdata,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wr_data
);

    localparam int NUM_CAP  = 100 * SCALE_SPEED;
    localparam int NUM_BASE = SCALE_FLOOR_PCT * SCALE_SPEED;
    localparam int NUM_W    = $clog2(NUM_CAP + 1);

    ezp_state_t state_reg, state_next;

    // configuration
    logic [11:0]        front_reg;
    logic signed [12:0] rear_reg;
    logic [10:0]        half_reg;
    logic [10:0]        mf_reg, mr_reg, ms_reg;
    logic [13:0]        decel_reg;
    logic [10:0]        rt_reg;

    // scan state
    logic signed [23:0] zone_min_x_reg, zone_max_x_reg;
    logic [11:0]        scaled_front_reg, scaled_rear_reg, scaled_side_reg;
    logic [15:0]        best_n_reg, best_d_reg;
    logic               hit_reg;

    // item working registers
    logic               last_reg;
    logic               vneg_reg;
    logic [12:0]        av_reg;
    logic [NUM_W-1:0]   num_reg;
    logic [15:0]        px_reg, py_reg;
    logic [16:0]        brake_reg;
    logic [1:0]         mrg_idx_reg;
    logic [15:0]        dx_reg, dy_reg, bx_reg;
    logic [11:0]        mx_reg;
    logic               small_reg;
    logic [23:0]        qx_reg, qy_reg;
    logic [21:0]        c_reg;
    logic [ACC_W-1:0]   acc_reg;
    logic               issued_reg;

    logic               out_valid_reg;
    logic [15:0]        out_n_reg, out_d_reg;
    logic               out_e_reg;

    arith_req_t req;
    arith_rsp_t rsp;
    logic       calc;
    logic       out_load;
    logic       in_fire;

    logic signed [12:0] speed_in;
    logic [12:0]        av_in;
    logic [31:0]        num_full;
    logic [10:0]        mrg_sel;
    logic [13:0]        decel_c;
    logic [15:0]        res_sat;

    logic signed [23:0] pxe, rear_ext, front_ext, brake_ext;
    logic signed [23:0] diff_hi, diff_lo, b1, b2, bm;
    logic               gt, lt;
    logic [16:0]        py_ext, ay;
    logic [15:0]        dx_c, dy_c, bx_c;
    logic [11:0]        mx_c;

    ezp_arith u_arith (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    assign in_fire  = s_tvalid && s_tready;
    assign speed_in = $signed(s_tdata[12:0]);
    assign av_in    = speed_in[12] ? 13'(-speed_in) : 13'(speed_in);
    assign num_full = 32'(NUM_BASE) + 32'(100 - SCALE_FLOOR_PCT) * 32'(av_in);
    assign decel_c  = (decel_reg < 14'd100) ? 14'd100 : decel_reg;
    assign res_sat  = (|rsp.res[ACC_W-1:16]) ? 16'hFFFF : rsp.res[15:0];

    always_comb
    begin
        case (mrg_idx_reg)
            2'd0:    mrg_sel = mf_reg;
            2'd1:    mrg_sel = mr_reg;
            default: mrg_sel = ms_reg;
        endcase
    end

    // point geometry against the stretched zone and the bare footprint
    assign pxe       = $signed({{8{px_reg[15]}}, px_reg});
    assign rear_ext  = $signed({{11{rear_reg[12]}}, rear_reg});
    assign front_ext = $signed({12'b0, front_reg});
    assign brake_ext = $signed({7'b0, brake_reg});
    assign diff_hi   = pxe - zone_max_x_reg;
    assign diff_lo   = zone_min_x_reg - pxe;
    assign gt        = pxe > zone_max_x_reg;
    assign lt        = pxe < zone_min_x_reg;
    assign dx_c      = gt ? diff_hi[15:0] : (lt ? diff_lo[15:0] : 16'd0);
    assign mx_c      = (!gt && lt) ? scaled_rear_reg : scaled_front_reg;
    assign py_ext    = {py_reg[15], py_reg};
    assign ay        = py_reg[15] ? 17'(-py_ext) : py_ext;
    assign dy_c      = (ay > {6'b0, half_reg}) ? 16'(ay - {6'b0, half_reg}) : 16'd0;
    assign b1        = pxe - front_ext;
    assign b2        = rear_ext - pxe;
    assign bm        = (b2 > b1) ? b2 : b1;
    assign bx_c      = bm[23] ? 16'd0 : bm[15:0];

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = (s_tuser == CMD_START) ? ST_BRK_SQ : ST_PT_PREP;
                end
            end
            ST_BRK_SQ:  if (rsp.done) state_next = ST_BRK_DIV;
            ST_BRK_DIV: if (rsp.done) state_next = ST_RT_MUL;
            ST_RT_MUL:  if (rsp.done) state_next = ST_RT_DIV;
            ST_RT_DIV:  if (rsp.done) state_next = ST_MRG_MUL;
            ST_MRG_MUL: if (rsp.done) state_next = ST_MRG_DIV;
            ST_MRG_DIV:
            begin
                if (rsp.done)
                begin
                    state_next = (mrg_idx_reg == 2'd2) ? ST_START_FIN : ST_MRG_MUL;
                end
            end
            ST_START_FIN: state_next = last_reg ? ST_OUT : ST_IDLE;
            ST_PT_PREP:   state_next = ST_QX;
            ST_QX:      if (rsp.done) state_next = ST_QY;
            ST_QY:      if (rsp.done) state_next = ST_QX_SQ;
            ST_QX_SQ:   if (rsp.done) state_next = ST_QY_SQ;
            ST_QY_SQ:   if (rsp.done) state_next = ST_N_SQRT;
            ST_N_SQRT:  if (rsp.done) state_next = ST_BX_SQ;
            ST_BX_SQ:   if (rsp.done) state_next = ST_BY_SQ;
            ST_BY_SQ:   if (rsp.done) state_next = ST_D_SQRT;
            ST_D_SQRT:
            begin
                if (rsp.done)
                begin
                    // far points cannot be inside the ellipse
                    state_next = small_reg ? ST_HA : (last_reg ? ST_OUT : ST_IDLE);
                end
            end
            ST_HA:      if (rsp.done) state_next = ST_HB;
            ST_HB:      if (rsp.done) state_next = ST_HC;
            ST_HC:      if (rsp.done) state_next = ST_HA_SQ;
            ST_HA_SQ:   if (rsp.done) state_next = ST_HB_SQ;
            ST_HB_SQ:   if (rsp.done) state_next = ST_HC_SQ;
            ST_HC_SQ:   if (rsp.done) state_next = last_reg ? ST_OUT : ST_IDLE;
            ST_OUT:     if (out_load) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer: handshake and arithmetic requests
    always_comb
    begin
        req      = '0;
        req.op   = OP_MUL;
        calc     = 1'b1;
        s_tready = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                calc     = 1'b0;
                s_tready = 1'b1;
            end
            ST_BRK_SQ:
            begin
                req.a = ACC_W'(av_reg);
                req.b = OPB_W'(av_reg);
                req.n = CNT_W'(13);
            end
            ST_BRK_DIV:
            begin
                req.op = OP_DIV;
                req.a  = acc_reg;
                req.b  = OPB_W'({decel_c, 1'b0});
                req.n  = CNT_W'(DIV_STEPS);
            end
            ST_RT_MUL:
            begin
                req.a = ACC_W'(av_reg);
                req.b = OPB_W'(rt_reg);
                req.n = CNT_W'(11);
            end
            ST_RT_DIV:
            begin
                req.op = OP_DIV;
                req.a  = acc_reg;
                req.b  = OPB_W'(1000);
                req.n  = CNT_W'(DIV_STEPS);
            end
            ST_MRG_MUL:
            begin
                req.a = ACC_W'(num_reg);
                req.b = OPB_W'(mrg_sel);
                req.n = CNT_W'(11);
            end
            ST_MRG_DIV:
            begin
                req.op = OP_DIV;
                req.a  = acc_reg;
                req.b  = OPB_W'(NUM_CAP);
                req.n  = CNT_W'(DIV_STEPS);
            end
            ST_QX:
            begin
                req.op = OP_DIV;
                req.a  = ACC_W'({dx_reg, 8'b0});
                req.b  = OPB_W'(mx_reg);
                req.n  = CNT_W'(DIV_STEPS);
            end
            ST_QY:
            begin
                req.op = OP_DIV;
                req.a  = ACC_W'({dy_reg, 8'b0});
                req.b  = OPB_W'(scaled_side_reg);
                req.n  = CNT_W'(DIV_STEPS);
            end
            ST_QX_SQ:
            begin
                req.a = ACC_W'(qx_reg);
                req.b = qx_reg;
                req.n = CNT_W'(24);
            end
            ST_QY_SQ:
            begin
                req.a = ACC_W'(qy_reg);
                req.b = qy_reg;
                req.n = CNT_W'(24);
            end
            ST_N_SQRT, ST_D_SQRT:
            begin
                req.op = OP_SQRT;
                req.a  = acc_reg;
                req.n  = CNT_W'(SQRT_STEPS);
            end
            ST_BX_SQ:
            begin
                req.a = ACC_W'(bx_reg);
                req.b = OPB_W'(bx_reg);
                req.n = CNT_W'(16);
            end
            ST_BY_SQ:
            begin
                req.a = ACC_W'(dy_reg);
                req.b = OPB_W'(dy_reg);
                req.n = CNT_W'(16);
            end
            ST_HA:
            begin
                req.a = ACC_W'(dx_reg);
                req.b = OPB_W'(scaled_side_reg);
                req.n = CNT_W'(12);
            end
            ST_HB:
            begin
                req.a = ACC_W'(dy_reg);
                req.b = OPB_W'(mx_reg);
                req.n = CNT_W'(12);
            end
            ST_HC:
            begin
                req.a = ACC_W'(mx_reg);
                req.b = OPB_W'(scaled_side_reg);
                req.n = CNT_W'(12);
            end
            ST_HA_SQ:
            begin
                req.a = ACC_W'(qx_reg[21:0]);
                req.b = OPB_W'(qx_reg[21:0]);
                req.n = CNT_W'(22);
            end
            ST_HB_SQ:
            begin
                req.a = ACC_W'(qy_reg[21:0]);
                req.b = OPB_W'(qy_reg[21:0]);
                req.n = CNT_W'(22);
            end
            ST_HC_SQ:
            begin
                req.a = ACC_W'(c_reg);
                req.b = OPB_W'(c_reg);
                req.n = CNT_W'(22);
            end
            ST_OUT:
            begin
                calc     = 1'b0;
                out_load = !out_valid_reg || m_tready;
            end
            default:
            begin
                calc = 1'b0;
            end
        endcase
        req.start = calc && !issued_reg;
    end

    // control, configuration and scan state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            issued_reg       <= 1'b0;
            out_valid_reg    <= 1'b0;
            front_reg        <= 12'd300;
            rear_reg         <= -13'sd300;
            half_reg         <= 11'd250;
            mf_reg           <= 11'd200;
            mr_reg           <= 11'd100;
            ms_reg           <= 11'd100;
            decel_reg        <= 14'd1000;
            rt_reg           <= 11'd100;
            zone_min_x_reg   <= '0;
            zone_max_x_reg   <= '0;
            scaled_front_reg <= 12'd1;
            scaled_rear_reg  <= 12'd1;
            scaled_side_reg  <= 12'd1;
            best_n_reg       <= 16'hFFFF;
            best_d_reg       <= 16'hFFFF;
            hit_reg          <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (req.start)
            begin
                issued_reg <= 1'b1;
            end
            else if (rsp.done)
            begin
                issued_reg <= 1'b0;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_FRONT:      front_reg <= cfg_wr_data[11:0];
                    REG_REAR:       rear_reg  <= $signed(cfg_wr_data[12:0]);
                    REG_HALF_WIDTH: half_reg  <= cfg_wr_data[10:0];
                    REG_MARGIN_F:   mf_reg    <= cfg_wr_data[10:0];
                    REG_MARGIN_R:   mr_reg    <= cfg_wr_data[10:0];
                    REG_MARGIN_S:   ms_reg    <= cfg_wr_data[10:0];
                    REG_DECEL:      decel_reg <= cfg_wr_data;
                    REG_REACTION:   rt_reg    <= cfg_wr_data[10:0];
                    default:        rt_reg    <= rt_reg;
                endcase
            end

            if (state_reg == ST_MRG_DIV && rsp.done)
            begin
                case (mrg_idx_reg)
                    2'd0:
                        scaled_front_reg <= (rsp.res[11:0] == 12'd0) ? 12'd1 : rsp.res[11:0];
                    2'd1:
                        scaled_rear_reg  <= (rsp.res[11:0] == 12'd0) ? 12'd1 : rsp.res[11:0];
                    default:
                        scaled_side_reg  <= (rsp.res[11:0] == 12'd0) ? 12'd1 : rsp.res[11:0];
                endcase
            end

            if (state_reg == ST_START_FIN)
            begin
                zone_min_x_reg <= vneg_reg ? rear_ext - brake_ext : rear_ext;
                zone_max_x_reg <= vneg_reg ? front_ext : front_ext + brake_ext;
                best_n_reg     <= 16'hFFFF;
                best_d_reg     <= 16'hFFFF;
                hit_reg        <= 1'b0;
            end

            if (state_reg == ST_N_SQRT && rsp.done && res_sat < best_n_reg)
            begin
                best_n_reg <= res_sat;
            end
            if (state_reg == ST_D_SQRT && rsp.done && res_sat < best_d_reg)
            begin
                best_d_reg <= res_sat;
            end
            // exact ellipse test: (dx*ms)^2 + (dy*mx)^2 < (mx*ms)^2
            if (state_reg == ST_HC_SQ && rsp.done && acc_reg < rsp.res)
            begin
                hit_reg <= 1'b1;
            end
        end
    end

    // item working registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            last_reg    <= s_tlast;
            vneg_reg    <= speed_in[12];
            av_reg      <= av_in;
            num_reg     <= (num_full > 32'(NUM_CAP)) ? NUM_W'(NUM_CAP) : NUM_W'(num_full);
            px_reg      <= s_tdata[28:13];
            py_reg      <= s_tdata[44:29];
            mrg_idx_reg <= 2'd0;
        end

        case (state_reg)
            ST_BRK_SQ, ST_RT_MUL, ST_MRG_MUL, ST_QX_SQ, ST_BX_SQ, ST_HA_SQ:
            begin
                if (rsp.done)
                begin
                    acc_reg <= rsp.res;
                end
            end
            ST_QY_SQ, ST_BY_SQ, ST_HB_SQ:
            begin
                if (rsp.done)
                begin
                    acc_reg <= acc_reg + rsp.res;
                end
            end
            ST_BRK_DIV:
            begin
                if (rsp.done)
                begin
                    brake_reg <= rsp.res[16:0];
                end
            end
            ST_RT_DIV:
            begin
                if (rsp.done)
                begin
                    brake_reg <= brake_reg + rsp.res[16:0];
                end
            end
            ST_MRG_DIV:
            begin
                if (rsp.done)
                begin
                    mrg_idx_reg <= mrg_idx_reg + 2'd1;
                end
            end
            ST_PT_PREP:
            begin
                dx_reg    <= dx_c;
                dy_reg    <= dy_c;
                bx_reg    <= bx_c;
                mx_reg    <= mx_c;
                small_reg <= ({4'b0, mx_c} > dx_c) && ({4'b0, scaled_side_reg} > dy_c);
            end
            ST_QX, ST_HA:
            begin
                if (rsp.done)
                begin
                    qx_reg <= rsp.res[23:0];
                end
            end
            ST_QY, ST_HB:
            begin
                if (rsp.done)
                begin
                    qy_reg <= rsp.res[23:0];
                end
            end
            ST_HC:
            begin
                if (rsp.done)
                begin
                    c_reg <= rsp.res[21:0];
                end
            end
            default:
            begin
                c_reg <= c_reg;
            end
        endcase

        if (out_load)
        begin
            out_n_reg <= best_n_reg;
            out_d_reg <= best_d_reg;
            out_e_reg <= hit_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, out_e_reg, out_d_reg, out_n_reg};

endmodule

`default_nettype wire

// ===== rtl/ezp_checker.sv =====
// ezp_checker: port-level checks of the emergency zone proximity check, bound to the top
// depends on ezp_pkg
`default_nettype none

module ezp_checker
    import ezp_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  s_tvalid,
    input wire logic                  s_tready,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic [OUT_DATA_W-1:0] m_tdata
);

    // a held result stays up
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    // an accepted item keeps the sequencer busy for at least the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while an item is at work");

    // a point inside the inflated zone has normalized distance below one
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[32] |-> m_tdata[15:0] < 16'd256)
        else $error("emergency without a normalized distance below the boundary");

endmodule

bind emergency_zone_proximity_check ezp_checker u_ezp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// ===== verif/emergency_zone_proximity_check_checker.sv =====
// emergency_zone_proximity_check_checker: watches the input, result and register ports,
// predicts each scan result and compares it field by field; depends on ezp_pkg
module emergency_zone_proximity_check_checker
    import ezp_pkg::*;
#(
    parameter int SCALE_FLOOR_PCT = SCALE_FLOOR_PCT_DEF,
    parameter int SCALE_SPEED     = SCALE_SPEED_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  s_tuser,
    input  logic                  s_tlast,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    output int                    errors,
    output int                    pending
);

    typedef struct packed {
        logic [15:0] min_norm;
        logic [15:0] nearest;
        logic        emerg;
    } zone_report_t;

    zone_report_t report_q[$];

    longint front_mm, rear_mm, half_mm, mrg_f, mrg_r, mrg_s, decel_cfg, react_ms;
    longint zone_lo, zone_hi, sc_front, sc_rear, sc_side;
    longint unsigned least_norm, least_dist;
    logic   inside_zone;

    function automatic longint unsigned int_sqrt(longint unsigned val);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > val)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (val >= root + bitv)
            begin
                val  = val - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic longint margin_scaled(longint margin, longint num);
        longint s;
        s = (margin * num) / (100 * SCALE_SPEED);
        return (s < 1) ? 1 : s;
    endfunction

    task automatic load_scan(input longint v);
        longint av, dec, brake, num;
        av    = (v < 0) ? -v : v;
        dec   = (decel_cfg < 100) ? 100 : decel_cfg;
        brake = (v * v) / (2 * dec) + (av * react_ms) / 1000;
        zone_lo = rear_mm;
        zone_hi = front_mm;
        if (v >= 0)
            zone_hi = zone_hi + brake;
        else
            zone_lo = zone_lo - brake;
        num = SCALE_FLOOR_PCT * SCALE_SPEED + (100 - SCALE_FLOOR_PCT) * av;
        if (num > 100 * SCALE_SPEED)
            num = 100 * SCALE_SPEED;
        sc_front    = margin_scaled(mrg_f, num);
        sc_rear     = margin_scaled(mrg_r, num);
        sc_side     = margin_scaled(mrg_s, num);
        least_norm  = 65535;
        least_dist  = 65535;
        inside_zone = 1'b0;
    endtask

    task automatic add_point(input longint px, input longint py);
        longint ay, dx, dy, mx, bx;
        longint unsigned qx, qy, nv, dv, lhs, rhs;
        ay = (py < 0) ? -py : py;
        dx = 0;
        dy = 0;
        mx = sc_front;
        if (px > zone_hi)
            dx = px - zone_hi;
        else if (px < zone_lo)
        begin
            dx = zone_lo - px;
            mx = sc_rear;
        end
        if (ay > half_mm)
            dy = ay - half_mm;
        qx = (dx * 256) / mx;
        qy = (dy * 256) / sc_side;
        nv = int_sqrt(qx * qx + qy * qy);
        if (nv > 65535)
            nv = 65535;
        if (nv < least_norm)
            least_norm = nv;
        lhs = longint'(dx * dx) * longint'(sc_side * sc_side)
            + longint'(dy * dy) * longint'(mx * mx);
        rhs = longint'(mx * mx) * longint'(sc_side * sc_side);
        if (lhs < rhs)
            inside_zone = 1'b1;
        bx = px - front_mm;
        if (rear_mm - px > bx)
            bx = rear_mm - px;
        if (bx < 0)
            bx = 0;
        dv = int_sqrt(longint'(bx * bx) + longint'(dy * dy));
        if (dv > 65535)
            dv = 65535;
        if (dv < least_dist)
            least_dist = dv;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        zone_report_t exp_r;
        zone_report_t got_r;
        zone_report_t new_r;
        if (!rst_n)
        begin
            front_mm = 300; rear_mm = -300; half_mm = 250;
            mrg_f = 200; mrg_r = 100; mrg_s = 100;
            decel_cfg = 1000; react_ms = 100;
            zone_lo = 0; zone_hi = 0;
            sc_front = 1; sc_rear = 1; sc_side = 1;
            least_norm = 65535; least_dist = 65535;
            inside_zone = 1'b0;
            errors <= 0;
            report_q.delete();
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_FRONT:      front_mm  = cfg_wr_data[11:0];
                    REG_REAR:       rear_mm   = longint'($signed(cfg_wr_data[12:0]));
                    REG_HALF_WIDTH: half_mm   = cfg_wr_data[10:0];
                    REG_MARGIN_F:   mrg_f     = cfg_wr_data[10:0];
                    REG_MARGIN_R:   mrg_r     = cfg_wr_data[10:0];
                    REG_MARGIN_S:   mrg_s     = cfg_wr_data[10:0];
                    REG_DECEL:      decel_cfg = cfg_wr_data[13:0];
                    REG_REACTION:   react_ms  = cfg_wr_data[10:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
            begin
                if (s_tuser == CMD_START)
                    load_scan(longint'($signed(s_tdata[12:0])));
                else
                    add_point(longint'($signed(s_tdata[28:13])),
                              longint'($signed(s_tdata[44:29])));
                if (s_tlast)
                begin
                    new_r = '{least_norm[15:0], least_dist[15:0], inside_zone};
                    report_q.insert(report_q.size(), new_r);
                end
            end
            if (m_tvalid && m_tready)
            begin
                got_r = '{m_tdata[15:0], m_tdata[31:16], m_tdata[32]};
                if (report_q.size() == 0)
                begin
                    $display("%0t: unexpected result %h", $time, m_tdata);
                    errors <= errors + 1;
                end
                else
                begin
                    exp_r = report_q.pop_front();
                    if (got_r.min_norm !== exp_r.min_norm || got_r.nearest !== exp_r.nearest
                        || got_r.emerg !== exp_r.emerg)
                    begin
                        $display({"%0t: mismatch expected norm %0d dist %0d emerg %0d,",
                                  " got norm %0d dist %0d emerg %0d"},
                                 $time, exp_r.min_norm, exp_r.nearest, exp_r.emerg,
                                 got_r.min_norm, got_r.nearest, got_r.emerg);
                        errors <= errors + 1;
                    end
                end
            end
        end
        pending <= report_q.size();
    end

endmodule

// ===== verif/emergency_zone_proximity_check_test.sv =====
// emergency_zone_proximity_check_test: stimulus, register phases and verdict
// depends on ezp_pkg, the block and emergency_zone_proximity_check_checker
module emergency_zone_proximity_check_test;
    import ezp_pkg::*;

    localparam int SETTLE_CYCLES = 500;
    localparam int STALL_LIMIT   = 5000;

    logic                  clk;
    logic                  rst_n;
    logic [IN_DATA_W-1:0]  s_tdata;   // speed, point_x, point_y, zero pad
    logic                  s_tuser;   // command
    logic                  s_tlast;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [OUT_DATA_W-1:0] m_tdata;   // min_normalized, footprint_dist, emergency, zero pad
    logic                  m_tvalid;
    logic                  m_tready;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wr_data;
    int                    errors;
    int                    pending;
    int                    sink_hold;
    int                    sink_draw;
    int                    quiet_cycles;
    bit                    no_gaps;

    emergency_zone_proximity_check u_dut (.*);

    emergency_zone_proximity_check_checker u_checker (.*);

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // result side back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            sink_hold <= 1;
        end
        else if (m_tvalid && m_tready)
        begin
            sink_draw = no_gaps ? 0 : $urandom_range(0, 9);
            m_tready  <= (sink_draw == 0);
            sink_hold <= sink_draw;
        end
        else if (!m_tready)
        begin
            if (sink_hold <= 1)
                m_tready <= 1'b1;
            sink_hold <= sink_hold - 1;
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("emergency_zone_proximity_check test failed");
            $finish;
        end
    end

    task automatic send_item(input logic cmd, input int speed, input int px, input int py,
                             input logic lst);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tuser  <= cmd;
        s_tlast  <= lst;
        s_tdata  <= {3'b000, py[15:0], px[15:0], speed[12:0]};
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic send_point(input int px, input int py, input logic lst);
        send_item(~CMD_START, $urandom, px, py, lst);
    endtask

    task automatic send_start(input int speed, input logic lst);
        send_item(CMD_START, speed, $urandom, $urandom, lst);
    endtask

    task automatic write_regs(input int vals[8]);
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        for (int i = 0; i < 8; i++)
        begin
            cfg_wr_en   <= 1'b1;
            cfg_index   <= CFG_IDX_W'(i);
            cfg_wr_data <= vals[i][CFG_DATA_W-1:0];
            @(posedge clk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    function automatic int rand_signed(input int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic int pick_speed();
        case ($urandom_range(0, 5))
            0: return 4000;
            1: return -4000;
            2: return 0;
            default: return rand_signed(4000);
        endcase
    endfunction

    task automatic run_scans(input int item_budget);
        int sent, npts, px, py;
        sent = 0;
        while (sent < item_budget)
        begin
            no_gaps = ($urandom_range(0, 7) == 0);
            if ($urandom_range(0, 9) == 0)
            begin
                // stray traffic: bare points, start marked last
                if ($urandom_range(0, 1))
                    send_point($urandom, $urandom, $urandom_range(0, 1));
                else
                    send_start(pick_speed(), 1'b1);
                sent++;
            end
            else
            begin
                send_start(pick_speed(), 1'b0);
                npts = $urandom_range(1, 10);
                for (int k = 0; k < npts; k++)
                begin
                    if ($urandom_range(0, 4) == 0)
                    begin
                        px = $urandom;
                        py = $urandom;
                    end
                    else
                    begin
                        px = rand_signed(10000);
                        py = rand_signed(3000);
                    end
                    send_point(px, py, k == npts - 1);
                end
                sent += npts + 1;
            end
        end
        no_gaps = 1'b0;
    endtask

    initial
    begin
        int regs[8];
        rst_n       = 1'b0;
        s_tdata     = '0;
        s_tuser     = 1'b0;
        s_tlast     = 1'b0;
        s_tvalid    = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_index   = '0;
        cfg_wr_data = '0;
        no_gaps     = 1'b0;
        quiet_cycles = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // points before any start use the reset zone
        send_point(0, 0, 1'b0);
        send_point(32767, -32768, 1'b1);
        send_start(0, 1'b1);
        send_start(4000, 1'b0);
        send_point(-32768, 32767, 1'b0);
        send_point(300, 250, 1'b0);
        send_point(8700, 0, 1'b1);
        // accumulating past last without a new start
        send_point(0, 0, 1'b1);
        send_start(-4000, 1'b0);
        send_point(-8700, 340, 1'b0);
        send_point(32767, 32767, 1'b1);
        send_start(-1, 1'b0);
        send_point(-301, 0, 1'b1);
        send_start(1000, 1'b0);
        send_point(-32768, -32768, 1'b1);
        run_scans(200);

        for (int ph = 0; ph < 7; ph++)
        begin
            case (ph)
                0: regs = '{0, 0, 0, 0, 0, 0, 0, 0};
                1: regs = '{4000, -4000, 2000, 2000, 2000, 2000, 10000, 2000};
                2: regs = '{100, 500, 300, 1, 2000, 1, 50, 0};       // rear beyond front
                3: regs = '{4095, -4096, 2047, 2047, 2047, 2047, 16383, 2047};
                default:
                begin
                    regs[0] = $urandom_range(0, 4000);
                    regs[1] = -int'($urandom_range(0, 4000));
                    regs[2] = $urandom_range(0, 2000);
                    regs[3] = $urandom_range(0, 2000);
                    regs[4] = $urandom_range(0, 2000);
                    regs[5] = $urandom_range(0, 2000);
                    regs[6] = $urandom_range(0, 10000);
                    regs[7] = $urandom_range(0, 2000);
                end
            endcase
            write_regs(regs);
            run_scans(220);
        end

        s_tvalid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("emergency_zone_proximity_check test passed");
        else
            $display("emergency_zone_proximity_check test failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/ezp_pkg.sv
rtl/ezp_arith.sv
rtl/emergency_zone_proximity_check.sv
rtl/ezp_checker.sv
verif/emergency_zone_proximity_check_checker.sv
verif/emergency_zone_proximity_check_test.sv
